// File: rtl/core/tked_pkg.sv
package tked_pkg;

  localparam int SeqCapacity = 32;
  localparam int CntW        = $clog2(SeqCapacity);
  localparam int FifoDepth   = 4;
  localparam int PtrW        = $clog2(FifoDepth);
  localparam int FillW       = $clog2(FifoDepth + 1);

  localparam logic OpByte  = 1'b0;
  localparam logic OpFlush = 1'b1;

  localparam logic [7:0] ByteEsc   = 8'h1b;
  localparam logic [7:0] ByteExit  = 8'h1d;
  localparam logic [7:0] ByteDel   = 8'h7f;
  localparam logic [7:0] ByteBs    = 8'h08;
  localparam logic [7:0] ByteTab   = 8'h09;
  localparam logic [7:0] ByteLbr   = 8'h5b;
  localparam logic [7:0] ByteUpO   = 8'h4f;
  localparam logic [7:0] ByteSemi  = 8'h3b;
  localparam logic [7:0] ByteZero  = 8'h30;
  localparam logic [7:0] ByteNine  = 8'h39;
  localparam logic [7:0] ByteFinLo = 8'h40;
  localparam logic [7:0] ByteFinHi = 8'h7e;
  localparam logic [7:0] ByteUpA   = 8'h41;
  localparam logic [7:0] ByteUpB   = 8'h42;
  localparam logic [7:0] ByteUpC   = 8'h43;
  localparam logic [7:0] ByteUpD   = 8'h44;
  localparam logic [7:0] ByteUpF   = 8'h46;
  localparam logic [7:0] ByteUpH   = 8'h48;
  localparam logic [7:0] ByteUpP   = 8'h50;
  localparam logic [7:0] ByteUpQ   = 8'h51;
  localparam logic [7:0] ByteUpR   = 8'h52;
  localparam logic [7:0] ByteUpS   = 8'h53;
  localparam logic [7:0] ByteUpZ   = 8'h5a;
  localparam logic [7:0] ByteTilde = 8'h7e;

  localparam logic [7:0] NkAltPrefix    = 8'd0;
  localparam logic [7:0] NkAppExit      = 8'd1;
  localparam logic [7:0] NkEscape       = 8'd2;
  localparam logic [7:0] NkDelete       = 8'd3;
  localparam logic [7:0] NkArrowBase    = 8'd4;
  localparam logic [7:0] NkHomeEndBase  = 8'd20;
  localparam logic [7:0] NkPageUp       = 8'd28;
  localparam logic [7:0] NkPageDown     = 8'd29;
  localparam logic [7:0] NkShiftPageUp  = 8'd30;
  localparam logic [7:0] NkShiftPageDown = 8'd31;
  localparam logic [7:0] NkF1           = 8'd32;

  typedef enum logic [3:0] {
    ModeNormal = 4'b0001,
    ModeEsc    = 4'b0010,
    ModeCsi    = 4'b0100,
    ModeSs3    = 4'b1000
  } mode_e;

  typedef struct packed {
    logic       alt;
    logic       named;
    logic [7:0] code;
    logic       pending;
  } entry_t;

endpackage

// File: rtl/core/tked_front.sv
module tked_front import tked_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_i,
  input  logic       op_i,
  input  logic [7:0] byte_i,
  output entry_t     ent_o,
  output logic       ent_valid_o
);

  mode_e            mode_q, mode_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [15:0]      p0_q, p0_d;
  logic [15:0]      p1_q, p1_d;
  logic [1:0]       slot_q, slot_d;
  logic [15:0]      dval_q, dval_d;
  logic             dseen_q, dseen_d;
  logic             sep_q, sep_d;

  logic [19:0] dmul;
  logic [15:0] dsat;
  logic        fin_push;
  logic [15:0] pval;
  logic [15:0] fp0;
  logic [15:0] fp1;
  logic [15:0] p1m;
  logic [2:0]  flags;
  logic [1:0]  variant;
  logic [7:0]  key;
  logic        key_ok;
  logic        clr;
  logic [7:0]  plain;

  assign dmul = ({4'b0, dval_q} << 3) + ({4'b0, dval_q} << 1)
              + {12'b0, byte_i - ByteZero};
  assign dsat = (|dmul[19:16]) ? 16'hffff : dmul[15:0];

  assign fin_push = dseen_q | sep_q;
  assign pval     = dseen_q ? dval_q : 16'd0;
  assign fp0      = (fin_push && slot_q == 2'd0) ? pval : p0_q;
  assign fp1      = (fin_push && slot_q == 2'd1) ? pval : p1_q;
  assign p1m      = fp1 - 16'd1;
  assign flags    = (fp1 > 16'd1) ? p1m[2:0] : 3'd0;
  assign variant  = {flags[2], flags[0]};
  assign plain    = (byte_i == ByteDel) ? ByteBs : byte_i;

  always_comb begin
    key    = '0;
    key_ok = 1'b0;
    if (byte_i inside {[ByteUpA:ByteUpD]}) begin
      key    = NkArrowBase + {4'b0, variant, 2'b0} + (byte_i - ByteUpA);
      key_ok = 1'b1;
    end else if (byte_i == ByteUpH || byte_i == ByteUpF) begin
      key    = NkHomeEndBase + {5'b0, variant, 1'b0} + {7'b0, byte_i == ByteUpF};
      key_ok = 1'b1;
    end else if (byte_i == ByteTilde) begin
      key_ok = 1'b1;
      if (fp0 inside {16'd1, 16'd7}) begin
        key = NkHomeEndBase + {5'b0, variant, 1'b0};
      end else if (fp0 inside {16'd4, 16'd8}) begin
        key = NkHomeEndBase + {5'b0, variant, 1'b0} + 8'd1;
      end else if (fp0 == 16'd3) begin
        key = NkDelete;
      end else if (fp0 == 16'd5) begin
        key = flags[0] ? NkShiftPageUp : NkPageUp;
      end else if (fp0 == 16'd6) begin
        key = flags[0] ? NkShiftPageDown : NkPageDown;
      end else if (fp0 inside {[16'd11:16'd15]}) begin
        key = NkF1 + (fp0[7:0] - 8'd11);
      end else if (fp0 inside {[16'd17:16'd21]}) begin
        key = NkF1 + 8'd5 + (fp0[7:0] - 8'd17);
      end else if (fp0 inside {16'd23, 16'd24}) begin
        key = NkF1 + 8'd10 + (fp0[7:0] - 8'd23);
      end else begin
        key_ok = 1'b0;
      end
    end
  end

  always_comb begin
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    slot_d      = slot_q;
    dval_d      = dval_q;
    dseen_d     = dseen_q;
    sep_d       = sep_q;
    ent_o       = '0;
    ent_valid_o = 1'b0;
    clr         = 1'b0;
    if (req_i) begin
      if (op_i == OpFlush) begin
        if (mode_q != ModeNormal) begin
          mode_d      = ModeNormal;
          clr         = 1'b1;
          ent_o.named = 1'b1;
          ent_o.code  = NkEscape;
          ent_valid_o = 1'b1;
        end
      end else begin
        case (mode_q)
          ModeNormal: begin
            if (byte_i == ByteEsc) begin
              mode_d = ModeEsc;
              clr    = 1'b1;
            end else if (byte_i == ByteExit) begin
              ent_o.named = 1'b1;
              ent_o.code  = NkAppExit;
              ent_valid_o = 1'b1;
            end else begin
              ent_o.code  = plain;
              ent_valid_o = 1'b1;
            end
          end
          ModeEsc: begin
            if (byte_i == ByteLbr) begin
              mode_d = ModeCsi;
              clr    = 1'b1;
            end else if (byte_i == ByteUpO) begin
              mode_d = ModeSs3;
            end else if (byte_i == ByteEsc) begin
              ent_o.named = 1'b1;
              ent_o.code  = NkEscape;
              ent_valid_o = 1'b1;
            end else begin
              mode_d      = ModeNormal;
              clr         = 1'b1;
              ent_o.alt   = 1'b1;
              ent_o.code  = plain;
              ent_valid_o = 1'b1;
            end
          end
          ModeCsi: begin
            if (byte_i inside {[ByteFinLo:ByteFinHi]}) begin
              mode_d = ModeNormal;
              clr    = 1'b1;
              if (byte_i == ByteUpZ) begin
                ent_o.alt   = flags[1];
                ent_o.code  = ByteTab;
                ent_valid_o = 1'b1;
              end else if (key_ok) begin
                ent_o.alt   = flags[1];
                ent_o.named = 1'b1;
                ent_o.code  = key;
                ent_valid_o = 1'b1;
              end
            end else if (cnt_q >= CntW'(SeqCapacity - 1)) begin
              mode_d = ModeNormal;
              clr    = 1'b1;
            end else begin
              cnt_d = cnt_q + 1'b1;
              if (byte_i inside {[ByteZero:ByteNine]}) begin
                dval_d  = dsat;
                dseen_d = 1'b1;
                sep_d   = 1'b0;
              end else if (byte_i == ByteSemi) begin
                if (slot_q == 2'd0) begin
                  p0_d = pval;
                end else if (slot_q == 2'd1) begin
                  p1_d = pval;
                end
                if (slot_q != 2'd3) begin
                  slot_d = slot_q + 2'd1;
                end
                dval_d  = '0;
                dseen_d = 1'b0;
                sep_d   = 1'b1;
              end else begin
                sep_d = 1'b0;
              end
            end
          end
          ModeSs3: begin
            mode_d      = ModeNormal;
            clr         = 1'b1;
            ent_o.named = 1'b1;
            ent_valid_o = 1'b1;
            case (byte_i)
              ByteUpA: ent_o.code = NkArrowBase;
              ByteUpB: ent_o.code = NkArrowBase + 8'd1;
              ByteUpC: ent_o.code = NkArrowBase + 8'd2;
              ByteUpD: ent_o.code = NkArrowBase + 8'd3;
              ByteUpH: ent_o.code = NkHomeEndBase;
              ByteUpF: ent_o.code = NkHomeEndBase + 8'd1;
              ByteUpP: ent_o.code = NkF1;
              ByteUpQ: ent_o.code = NkF1 + 8'd1;
              ByteUpR: ent_o.code = NkF1 + 8'd2;
              ByteUpS: ent_o.code = NkF1 + 8'd3;
              default: ent_valid_o = 1'b0;
            endcase
          end
          default: begin
            mode_d = ModeNormal;
            clr    = 1'b1;
          end
        endcase
      end
      if (clr) begin
        cnt_d   = '0;
        p0_d    = '0;
        p1_d    = '0;
        slot_d  = '0;
        dval_d  = '0;
        dseen_d = 1'b0;
        sep_d   = 1'b0;
      end
      ent_o.pending = (mode_d != ModeNormal);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeNormal;
      cnt_q   <= '0;
      p0_q    <= '0;
      p1_q    <= '0;
      slot_q  <= '0;
      dval_q  <= '0;
      dseen_q <= 1'b0;
      sep_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      slot_q  <= slot_d;
      dval_q  <= dval_d;
      dseen_q <= dseen_d;
      sep_q   <= sep_d;
    end
  end

endmodule

// File: rtl/core/tked_fifo.sv
module tked_fifo import tked_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  entry_t wr_data_i,
  input  logic   rd_i,
  output entry_t rd_data_o,
  output logic   valid_o,
  output logic   full_o
);

  entry_t           mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_wr;
  logic             do_rd;

  assign valid_o   = (fill_q != '0);
  assign full_o    = (fill_q == FillW'(FifoDepth));
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      fill_d = fill_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// File: rtl/core/tked_back.sv
module tked_back import tked_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  entry_t     head_i,
  input  logic       head_valid_i,
  output logic       deq_o,
  input  logic       pop,
  output logic       empty,
  output logic       is_named_o,
  output logic [7:0] code_o,
  output logic       last_o,
  output logic       pending_o
);

  logic pre_done_q, pre_done_d;
  logic show_prefix;
  logic take;

  assign show_prefix = head_i.alt && !pre_done_q;
  assign take        = pop && head_valid_i;
  assign empty       = !head_valid_i;
  assign is_named_o  = show_prefix ? 1'b1 : head_i.named;
  assign code_o      = show_prefix ? NkAltPrefix : head_i.code;
  assign last_o      = !show_prefix;
  assign pending_o   = head_i.pending;
  assign deq_o       = take && !show_prefix;

  always_comb begin
    pre_done_d = pre_done_q;
    if (take) begin
      pre_done_d = show_prefix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_done_q <= 1'b0;
    end else begin
      pre_done_q <= pre_done_d;
    end
  end

endmodule

// File: rtl/core/terminal_key_escape_decoder_unit.sv
// Channel  | Direction | Handshake  | Payload
// ---------+-----------+------------+-----------------------------------------
// input    | in        | push, full | operation_i, rx_byte_i
// result   | out       | empty, pop | is_named_o, code_o, last_o, pending_o
//
// One request is decoded in the cycle it is accepted; one can enter every cycle unless full.
// Its result is queued; results leave one per cycle while pop is high and empty is low.
// A four-entry queue sits between decoder and result stage; full rises only when it is full.
// A request with an Alt prefix holds one queue entry and takes two pops.
// Reset returns the decoder to normal mode and empties the queue.
module terminal_key_escape_decoder_unit import tked_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       operation_i,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       is_named_o,
  output logic [7:0] code_o,
  output logic       last_o,
  output logic       pending_o
);

  entry_t ent;
  logic   ent_valid;
  entry_t head;
  logic   head_valid;
  logic   deq;
  logic   accept;

  assign accept = push && !full;

  tked_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (accept),
    .op_i        (operation_i),
    .byte_i      (rx_byte_i),
    .ent_o       (ent),
    .ent_valid_o (ent_valid)
  );

  tked_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (ent_valid),
    .wr_data_i (ent),
    .rd_i      (deq),
    .rd_data_o (head),
    .valid_o   (head_valid),
    .full_o    (full)
  );

  tked_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .deq_o        (deq),
    .pop          (pop),
    .empty        (empty),
    .is_named_o   (is_named_o),
    .code_o       (code_o),
    .last_o       (last_o),
    .pending_o    (pending_o)
  );

endmodule
